[src/pal_enc_pkg.sv]
// Shared types and constants of the palette colour encoder.
package pal_enc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 512;
    localparam int PAL_ADDR_W          = 9;

    // Command codes of a request transfer
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    // Register offsets
    localparam logic [2:0] OFF_CTRL    = 3'd0;
    localparam logic [2:0] OFF_PTR_LO  = 3'd2;
    localparam logic [2:0] OFF_PTR_HI  = 3'd3;
    localparam logic [2:0] OFF_DATA_LO = 3'd4;
    localparam logic [2:0] OFF_DATA_HI = 3'd5;

    localparam logic [7:0] READ_IDLE_BYTE = 8'hFF;
    localparam logic [7:0] READ_HI_MASK   = 8'hFE;

    // floor(x / 1000) = (x * LUMA_RECIP) >> LUMA_SHIFT, exact for x < 2^28 / 544
    localparam int         LUMA_SHIFT = 28;
    localparam logic [18:0] LUMA_RECIP = 19'd268436;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic [8:0] pixel_index;
    } req_t;

    typedef struct packed {
        logic       is_pixel;
        logic [7:0] read_data;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rsp_t;

endpackage

[src/pal_enc_if.sv]
// Request and result channel interfaces of the palette colour encoder.
interface pal_enc_req_if;
    import pal_enc_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pal_enc_rsp_if;
    import pal_enc_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/pal_enc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pal_enc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 512,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/palette_color_encoder.sv]
// Palette colour encoder: register access to a 9-bit palette and pixel colour lookup.
//
// Usage: one request channel (req) carries register writes, register reads and
// pixel lookups; one result channel (rsp) returns read data or an RGB triple.
// Writes give no result; reads and pixel lookups give exactly one, in order.
// Result valid is registered: a request passes stage 1, stage 2, stage 3 and the output
// register before its result is offered. A new request is taken every cycle while rsp
// is not stalled and no clearing sweep runs, so the sustained rate is one item per cycle;
// each palette RAM's single read port carries one access per cycle.
// The palette sits in two RAMs (low byte, bit 8) so that byte writes need no
// read-modify-write.
// After reset the palette is swept to zero, one entry per cycle, from entry 0 up to
// entry PALETTE_ENTRIES-1; req.ready stays low for that time. Pointer and
// control byte clear at once.
// When a result waits with rsp.ready low the whole pipeline holds and req.ready
// drops; nothing is lost. Grayscale luma is formed with a constant reciprocal multiply.
module palette_color_encoder #(
    parameter int PALETTE_ENTRIES = pal_enc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pal_enc_req_if.sink  req,
    pal_enc_rsp_if.source rsp
);
    import pal_enc_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    localparam logic [1:0] RSEL_LO = 2'd0;
    localparam logic [1:0] RSEL_HI = 2'd1;
    localparam logic [1:0] RSEL_FF = 2'd2;

    // clearing sweep
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [PAL_ADDR_W-1:0] ptr_reg, ptr_next;
    logic [7:0]            ctrl_reg, ctrl_next;

    logic advance, acc;
    logic is_wr, is_rd, is_px;
    logic [PAL_ADDR_W-1:0] rd_addr;
    logic ptr_inr, rd_inr;

    logic          lo_we, hi_we;
    logic [AW-1:0] waddr;
    logic [7:0]    lo_wdata;
    logic          hi_wdata;
    logic [7:0]    lo_rdata;
    logic          hi_rdata;

    // stage 1: RAM data present
    logic       s1_valid_reg, s1_pixel_reg, s1_gray_reg, s1_inr_reg;
    logic [1:0] s1_rsel_reg;

    logic [8:0]  s1_entry;
    logic [7:0]  s1_rd, s1_r, s1_g, s1_b;
    logic [17:0] s1_sum;

    // stage 2: scaled levels and weighted sum
    logic        s2_valid_reg, s2_pixel_reg, s2_gray_reg;
    logic [7:0]  s2_rd_reg, s2_r_reg, s2_g_reg, s2_b_reg;
    logic [17:0] s2_sum_reg;
    logic [36:0] s2_prod;

    // stage 3: luma
    logic       s3_valid_reg, s3_pixel_reg, s3_gray_reg;
    logic [7:0] s3_rd_reg, s3_r_reg, s3_g_reg, s3_b_reg, s3_luma_reg;

    logic out_valid_reg;
    rsp_t out_reg, out_next;

    function automatic logic [7:0] scale36(input logic [2:0] c);
        return {c, 5'd0} + {3'd0, c, 2'd0};
    endfunction

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance && !clearing_reg;
    assign acc       = req.valid && req.ready;

    assign is_wr = req.data.command == CMD_WRITE;
    assign is_rd = req.data.command == CMD_READ;
    assign is_px = req.data.command == CMD_PIXEL;

    always_comb
    begin
        if (is_px)
        begin
            if (req.data.pixel_index[3:0] == 4'd0)
                rd_addr = {req.data.pixel_index[8], 8'd0};
            else
                rd_addr = req.data.pixel_index;
        end
        else
        begin
            rd_addr = ptr_reg;
        end
    end

    assign ptr_inr = {1'b0, ptr_reg} < (PAL_ADDR_W + 1)'(PALETTE_ENTRIES);
    assign rd_inr  = {1'b0, rd_addr} < (PAL_ADDR_W + 1)'(PALETTE_ENTRIES);

    // clearing sweep, register writes and pointer update
    always_comb
    begin
        ptr_next      = ptr_reg;
        ctrl_next     = ctrl_reg;
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        lo_we         = 1'b0;
        hi_we         = 1'b0;
        waddr         = ptr_reg[AW-1:0];
        lo_wdata      = req.data.write_data;
        hi_wdata      = req.data.write_data[0];

        if (clearing_reg)
        begin
            lo_we         = 1'b1;
            hi_we         = 1'b1;
            waddr         = clr_addr_reg;
            lo_wdata      = 8'd0;
            hi_wdata      = 1'b0;
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(PALETTE_ENTRIES - 1))
                clearing_next = 1'b0;
        end
        else if (acc && is_wr)
        begin
            unique case (req.data.reg_offset)
                OFF_CTRL:    ctrl_next = req.data.write_data;
                OFF_PTR_LO:  ptr_next = {ptr_reg[8], req.data.write_data};
                OFF_PTR_HI:  ptr_next = {req.data.write_data[0], ptr_reg[7:0]};
                OFF_DATA_LO: lo_we = ptr_inr;
                OFF_DATA_HI:
                begin
                    hi_we    = ptr_inr;
                    ptr_next = ptr_reg + PAL_ADDR_W'(1);
                end
                default: ;
            endcase
        end
        else if (acc && is_rd && req.data.reg_offset == OFF_DATA_HI)
        begin
            ptr_next = ptr_reg + PAL_ADDR_W'(1);
        end
    end

    pal_enc_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram_lo (
        .clk   (clk),
        .we    (lo_we),
        .waddr (waddr),
        .wdata (lo_wdata),
        .re    (acc),
        .raddr (rd_addr[AW-1:0]),
        .rdata (lo_rdata)
    );

    pal_enc_ram #(
        .WIDTH (1),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram_hi (
        .clk   (clk),
        .we    (hi_we),
        .waddr (waddr),
        .wdata (hi_wdata),
        .re    (acc),
        .raddr (rd_addr[AW-1:0]),
        .rdata (hi_rdata)
    );

    // stage 1 datapath: entry packs blue [2:0], red [5:3], green [8:6]
    assign s1_entry = s1_inr_reg ? {hi_rdata, lo_rdata} : 9'd0;

    always_comb
    begin
        case (s1_rsel_reg)
            RSEL_LO: s1_rd = s1_entry[7:0];
            RSEL_HI: s1_rd = READ_HI_MASK | {7'd0, s1_entry[8]};
            default: s1_rd = READ_IDLE_BYTE;
        endcase
    end

    assign s1_b = scale36(s1_entry[2:0]);
    assign s1_r = scale36(s1_entry[5:3]);
    assign s1_g = scale36(s1_entry[8:6]);

    assign s1_sum = 18'(s1_r) * 18'd300 + 18'(s1_g) * 18'd589
                  + 18'(s1_b) * 18'd111 + 18'd500;

    assign s2_prod = 37'(s2_sum_reg) * 37'(LUMA_RECIP);

    always_comb
    begin
        out_next = '0;
        out_next.is_pixel = s3_pixel_reg;
        if (!s3_pixel_reg)
        begin
            out_next.read_data = s3_rd_reg;
        end
        else if (s3_gray_reg)
        begin
            out_next.red   = s3_luma_reg;
            out_next.green = s3_luma_reg;
            out_next.blue  = s3_luma_reg;
        end
        else
        begin
            out_next.red   = s3_r_reg;
            out_next.green = s3_g_reg;
            out_next.blue  = s3_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            ptr_reg       <= '0;
            ctrl_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            ptr_reg      <= ptr_next;
            ctrl_reg     <= ctrl_next;
            if (advance)
            begin
                s1_valid_reg  <= acc && (is_rd || is_px);
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pixel_reg <= is_px;
            s1_gray_reg  <= ctrl_reg[7];
            s1_inr_reg   <= rd_inr;
            if (req.data.reg_offset == OFF_DATA_LO)
                s1_rsel_reg <= RSEL_LO;
            else if (req.data.reg_offset == OFF_DATA_HI)
                s1_rsel_reg <= RSEL_HI;
            else
                s1_rsel_reg <= RSEL_FF;

            s2_pixel_reg <= s1_pixel_reg;
            s2_gray_reg  <= s1_gray_reg;
            s2_rd_reg    <= s1_rd;
            s2_r_reg     <= s1_r;
            s2_g_reg     <= s1_g;
            s2_b_reg     <= s1_b;
            s2_sum_reg   <= s1_sum;

            s3_pixel_reg <= s2_pixel_reg;
            s3_gray_reg  <= s2_gray_reg;
            s3_rd_reg    <= s2_rd_reg;
            s3_r_reg     <= s2_r_reg;
            s3_g_reg     <= s2_g_reg;
            s3_b_reg     <= s2_b_reg;
            s3_luma_reg  <= s2_prod[LUMA_SHIFT+7:LUMA_SHIFT];

            out_reg      <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the palette colour encoder: register access and pixel lookup.
`timescale 1ns / 1ps

import pal_enc_pkg::*;

// Holds a copy of the palette, pointer and control byte and the queue of results still owed
class palette_checker;
    localparam int         GRAY_BIT   = 7;
    localparam int         LEVEL_STEP = 36;

    logic [8:0] colour_ram [PALETTE_ENTRIES_DEF];
    logic [8:0] addr_ptr;
    logic [7:0] ctrl_reg;
    rsp_t       owed_results [$];
    int         errors;
    int         n_pixels;
    int         n_gray;
    int         n_reads;
    int         n_writes;
    int         n_ignored;
    int         n_checked;

    function new();
        foreach (colour_ram[i])
            colour_ram[i] = '0;
        addr_ptr  = '0;
        ctrl_reg  = '0;
        errors    = 0;
        n_pixels  = 0;
        n_gray    = 0;
        n_reads   = 0;
        n_writes  = 0;
        n_ignored = 0;
        n_checked = 0;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    // Work out the colour for one pixel index
    function rsp_t lookup_colour(logic [8:0] index);
        rsp_t       res;
        logic [8:0] addr;
        logic [8:0] entry;
        int         r;
        int         g;
        int         b;
        int         y;
        res = '0;
        // an index with low nibble zero takes the backdrop entry of its half
        addr  = (index[3:0] == 4'd0) ? {index[8], 8'd0} : index;
        entry = colour_ram[addr];
        b = LEVEL_STEP * int'(entry[2:0]);
        r = LEVEL_STEP * int'(entry[5:3]);
        g = LEVEL_STEP * int'(entry[8:6]);
        if (ctrl_reg[GRAY_BIT]) begin
            y = (300 * r + 589 * g + 111 * b + 500) / 1000;
            r = y;
            g = y;
            b = y;
            n_gray++;
        end
        res.is_pixel = 1'b1;
        res.red      = 8'(r);
        res.green    = 8'(g);
        res.blue     = 8'(b);
        return res;
    endfunction

    // Called for each accepted request transfer
    function void note_request(req_t rq);
        rsp_t res;
        res = '0;
        case (rq.command)
            CMD_WRITE: begin
                n_writes++;
                case (rq.reg_offset)
                    OFF_CTRL:    ctrl_reg = rq.write_data;
                    OFF_PTR_LO:  addr_ptr[7:0] = rq.write_data;
                    OFF_PTR_HI:  addr_ptr[8] = rq.write_data[0];
                    OFF_DATA_LO: colour_ram[addr_ptr][7:0] = rq.write_data;
                    OFF_DATA_HI:
                    begin
                        colour_ram[addr_ptr][8] = rq.write_data[0];
                        addr_ptr = addr_ptr + 9'd1;
                    end
                    default: n_ignored++;
                endcase
            end
            CMD_READ: begin
                n_reads++;
                res.read_data = READ_IDLE_BYTE;
                if (rq.reg_offset == OFF_DATA_LO)
                    res.read_data = colour_ram[addr_ptr][7:0];
                else if (rq.reg_offset == OFF_DATA_HI) begin
                    res.read_data = READ_HI_MASK | {7'd0, colour_ram[addr_ptr][8]};
                    addr_ptr = addr_ptr + 9'd1;
                end
                owed_results.push_back(res);
            end
            CMD_PIXEL: begin
                n_pixels++;
                owed_results.push_back(lookup_colour(rq.pixel_index));
            end
            default: n_ignored++;
        endcase
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // Called for each accepted result transfer
    function void check_result(rsp_t got);
        rsp_t want;
        if (owed_results.size() == 0) begin
            $error("result %h arrived with nothing outstanding", got);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        n_checked++;
        check_field("is_pixel", {7'd0, want.is_pixel}, {7'd0, got.is_pixel});
        check_field("read_data", want.read_data, got.read_data);
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
    endfunction
endclass

module tb;
    import pal_enc_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [2:0] OFF_UNUSED_1 = 3'd1;
    localparam logic [2:0] OFF_UNUSED_6 = 3'd6;
    localparam logic [2:0] OFF_UNUSED_7 = 3'd7;
    localparam int ITEM_TARGET   = 425;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 250000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pal_enc_req_if req_if ();
    pal_enc_rsp_if rsp_if ();

    palette_color_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    palette_checker sb = new();

    int         items_sent = 0;
    int         cycle_count = 0;
    bit         long_hold_done = 1'b0;
    logic [8:0] last_base = '0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(12, 48);
        return $urandom_range(1, 3);
    endfunction

    function automatic req_t wr(logic [2:0] off, logic [7:0] wdata);
        req_t rq;
        rq.command     = CMD_WRITE;
        rq.reg_offset  = off;
        rq.write_data  = wdata;
        rq.pixel_index = 9'($urandom);
        return rq;
    endfunction

    function automatic req_t rd(logic [2:0] off);
        req_t rq;
        rq.command     = CMD_READ;
        rq.reg_offset  = off;
        rq.write_data  = 8'($urandom);
        rq.pixel_index = 9'($urandom);
        return rq;
    endfunction

    function automatic req_t px(logic [8:0] index);
        req_t rq;
        rq.command     = CMD_PIXEL;
        rq.reg_offset  = 3'($urandom);
        rq.write_data  = 8'($urandom);
        rq.pixel_index = index;
        return rq;
    endfunction

    function automatic logic [8:0] pick_index();
        logic [8:0] idx;
        if ($urandom_range(0, 1) == 0)
            idx = 9'($urandom);
        else
            idx = last_base + 9'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0)
            idx[3:0] = 4'd0;
        return idx;
    endfunction

    // Offer one request and hold it until the transfer happens
    task automatic send_item(input req_t item);
        int gap;
        gap = ($urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (item.command != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic set_pointer(input logic [8:0] addr);
        send_item(wr(OFF_PTR_LO, addr[7:0]));
        send_item(wr(OFF_PTR_HI, {7'($urandom), addr[8]}));
    endtask

    task automatic random_sequence();
        int   kind;
        int   n;
        req_t rq;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(1, 8);
        if (kind < 4) begin
            repeat (n) send_item(px(pick_index()));
        end
        else if (kind < 6) begin
            // palette load, now and then missing the high write
            last_base = 9'($urandom);
            set_pointer(last_base);
            repeat (n)
            begin
                send_item(wr(OFF_DATA_LO, 8'($urandom)));
                if ($urandom_range(0, 7) != 0)
                    send_item(wr(OFF_DATA_HI, 8'($urandom)));
            end
        end
        else if (kind < 8) begin
            if ($urandom_range(0, 3) != 0)
                set_pointer(last_base);
            repeat (n)
            begin
                if ($urandom_range(0, 5) != 0)
                    send_item(rd(OFF_DATA_LO));
                send_item(rd(OFF_DATA_HI));
            end
        end
        else if (kind == 8) begin
            send_item(wr(OFF_CTRL, 8'($urandom)));
        end
        else begin
            repeat ($urandom_range(1, 4))
            begin
                rq.command     = 2'($urandom);
                rq.reg_offset  = 3'($urandom);
                rq.write_data  = 8'($urandom);
                rq.pixel_index = 9'($urandom);
                send_item(rq);
            end
        end
    endtask

    // Both transfers are sampled on the edge, before any driver update lands
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.data);
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.data);
        end
    end

    // Result side: random stalls, plus one long hold-off to back the pipe up
    initial
    begin
        rsp_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && sb.n_checked >= 40) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
            else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // fresh palette reads back as zero
        send_item(px(9'h000));
        // entry 256 full scale, pointer then steps past it
        set_pointer(9'h100);
        send_item(wr(OFF_DATA_LO, 8'hFF));
        send_item(wr(OFF_DATA_HI, 8'h01));
        set_pointer(9'h000);
        send_item(wr(OFF_DATA_LO, 8'hAA));
        send_item(wr(OFF_DATA_HI, 8'hFF));
        // backdrop substitution in both halves, plus a plain index
        send_item(px(9'h1F0));
        send_item(px(9'h010));
        send_item(px(9'h1FF));
        // grayscale: brightest entry gives the largest luma
        send_item(wr(OFF_CTRL, 8'h80));
        send_item(px(9'h100));
        send_item(px(9'h000));
        send_item(wr(OFF_CTRL, 8'h7F));
        send_item(px(9'h100));
        // writes to spare offsets and the unused command change nothing
        send_item(wr(OFF_UNUSED_1, 8'hFF));
        send_item(wr(OFF_UNUSED_6, 8'h00));
        send_item(wr(OFF_UNUSED_7, 8'h5A));
        send_item('{command: CMD_UNUSED, reg_offset: OFF_DATA_HI, write_data: 8'hFF,
                    pixel_index: 9'h1FF});
        // read every offset from entry 0
        set_pointer(9'h000);
        for (int o = 0; o < 8; o++)
            send_item(rd(3'(o)));

        while (items_sent < ITEM_TARGET)
            random_sequence();
        req_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d pixels (%0d grayscale), %0d reads, %0d writes",
                 items_sent, sb.n_pixels, sb.n_gray, sb.n_reads, sb.n_writes);
        $display("%0d requests ignored, %0d results checked, long output stall %s",
                 sb.n_ignored, sb.n_checked, long_hold_done ? "done" : "not reached");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[palette_color_encoder.f]
src/pal_enc_pkg.sv
src/pal_enc_if.sv
src/pal_enc_ram.sv
src/palette_color_encoder.sv
tb/sv/tb.sv
